/* design/lut3d_pkg.sv */
// Shared types and constants for the trilinear 3D colour look-up table.
// No dependencies; used by lut3d_trilinear_color_map.
package lut3d_pkg;

    localparam int MAX_GRID   = 33;
    localparam int VALUE_BITS = 20;
    localparam int FRAC_BITS  = 16;

    localparam int GRID_BITS  = $clog2(MAX_GRID + 1);
    localparam int SQ_BITS    = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int LUT_DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_BITS  = $clog2(LUT_DEPTH);
    localparam int ENTRY_BITS = 3 * VALUE_BITS;
    localparam int NORM_BITS  = FRAC_BITS + 1;
    localparam int SCL_BITS   = NORM_BITS + GRID_BITS;
    localparam int PROD_BITS  = VALUE_BITS + 1 + NORM_BITS;
    localparam int CORNERS    = 8;
    localparam int PAIRS      = 4;
    localparam int LEVELS     = 3;
    localparam int CFG_IDX_BITS = 3;

    // pipeline stage positions
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int ST_IN     = 0;
    localparam int ST_CLAMP  = 1;
    localparam int ST_DIV0   = 2;
    localparam int ST_SCALE  = ST_DIV0 + DIV_STEPS;
    localparam int ST_BASE   = ST_SCALE + 1;
    localparam int ST_ADDR   = ST_BASE + 1;
    localparam int ST_RD     = ST_ADDR + 1;
    localparam int ST_BLEND  = ST_RD + 1;
    localparam int STAGES    = ST_BLEND + 3 * LEVELS;

    localparam logic [VALUE_BITS-1:0] ONE_VALUE = VALUE_BITS'(1) << FRAC_BITS;
    localparam logic [NORM_BITS-1:0]  ONE_NORM  = NORM_BITS'(1) << FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID      = 3'd0,
        REG_MIN_RED   = 3'd1,
        REG_MIN_GREEN = 3'd2,
        REG_MIN_BLUE  = 3'd3,
        REG_MAX_RED   = 3'd4,
        REG_MAX_GREEN = 3'd5,
        REG_MAX_BLUE  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        op_t                             op;
        logic [ADDR_BITS-1:0]            idx;
        logic [2:0][VALUE_BITS-1:0]      px;
        logic [2:0][FRAC_BITS-1:0]       frac;
    } pl_t;

endpackage

/* design/lut3d_trilinear_color_map.sv */
// Trilinear 3D colour look-up table: table load and pixel mapping pipeline.
// Depends on lut3d_pkg (types, widths, stage positions, register indexes).
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  input   | s_valid s_ready s_operation s_entry_index     | in
//          | s_red s_green s_blue                          |
//  result  | m_valid m_ready m_red_out m_green_out         | out
//          | m_blue_out                                    |
//  config  | cfg_wr_en cfg_index cfg_wdata                 | in
//
// One transfer per clock while the result side is not stalled; the pipeline
// holds the 17-step normalising divider, the table read and three blend levels of three stages each.
// The eight corners come from eight replicated table banks, one read each.
// Synchronous reset clears the valid bits, grid and minimum registers and sets the maximums to one.
// When a result is held and not taken the whole pipeline stalls.
module lut3d_trilinear_color_map (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_operation,
    input  logic [15:0]                            s_entry_index,
    input  logic signed [lut3d_pkg::VALUE_BITS-1:0] s_red,
    input  logic signed [lut3d_pkg::VALUE_BITS-1:0] s_green,
    input  logic signed [lut3d_pkg::VALUE_BITS-1:0] s_blue,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lut3d_pkg::VALUE_BITS-1:0] m_red_out,
    output logic signed [lut3d_pkg::VALUE_BITS-1:0] m_green_out,
    output logic signed [lut3d_pkg::VALUE_BITS-1:0] m_blue_out,
    input  logic                                   cfg_wr_en,
    input  logic [lut3d_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lut3d_pkg::VALUE_BITS-1:0]       cfg_wdata
);

    localparam int VB   = lut3d_pkg::VALUE_BITS;
    localparam int FB   = lut3d_pkg::FRAC_BITS;
    localparam int GB   = lut3d_pkg::GRID_BITS;
    localparam int AB   = lut3d_pkg::ADDR_BITS;
    localparam int NS   = lut3d_pkg::STAGES;
    localparam int DS   = lut3d_pkg::DIV_STEPS;
    localparam int LAST = NS - 1;

    // configuration
    logic [GB-1:0] grid_reg;
    logic [VB-1:0] min_reg [3];
    logic [VB-1:0] max_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                min_reg[c] <= '0;
                max_reg[c] <= lut3d_pkg::ONE_VALUE;
            end
        end else if (cfg_wr_en) begin
            case (lut3d_pkg::reg_idx_t'(cfg_index))
                lut3d_pkg::REG_GRID:      grid_reg   <= cfg_wdata[GB-1:0];
                lut3d_pkg::REG_MIN_RED:   min_reg[0] <= cfg_wdata;
                lut3d_pkg::REG_MIN_GREEN: min_reg[1] <= cfg_wdata;
                lut3d_pkg::REG_MIN_BLUE:  min_reg[2] <= cfg_wdata;
                lut3d_pkg::REG_MAX_RED:   max_reg[0] <= cfg_wdata;
                lut3d_pkg::REG_MAX_GREEN: max_reg[1] <= cfg_wdata;
                lut3d_pkg::REG_MAX_BLUE:  max_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // values derived from configuration; the user must keep them static while items are in flight (not enforced here)
    logic [GB-1:0]                    n_reg, n_next, nm1_reg, nm1_next;
    logic [lut3d_pkg::SQ_BITS-1:0]    nn_reg, nn_next;
    logic                             bypass_reg, bypass_next;
    logic [VB-1:0]                    den_reg [3], den_next [3];
    logic                             den_pos_reg [3], den_pos_next [3];

    always_comb begin
        logic signed [VB:0] dn;
        n_next = (grid_reg > GB'(lut3d_pkg::MAX_GRID)) ? GB'(lut3d_pkg::MAX_GRID)
                                                       : grid_reg;
        nm1_next    = n_next - GB'(1);
        nn_next     = lut3d_pkg::SQ_BITS'(n_next) * lut3d_pkg::SQ_BITS'(n_next);
        bypass_next = (grid_reg < GB'(2));
        for (int c = 0; c < 3; c++) begin
            dn = $signed({max_reg[c][VB-1], max_reg[c]})
               - $signed({min_reg[c][VB-1], min_reg[c]});
            den_pos_next[c] = !dn[VB] && (dn != '0);
            den_next[c]     = den_pos_next[c] ? dn[VB-1:0] : VB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        nm1_reg    <= nm1_next;
        nn_reg     <= nn_next;
        bypass_reg <= bypass_next;
        for (int c = 0; c < 3; c++) begin
            den_reg[c]     <= den_next[c];
            den_pos_reg[c] <= den_pos_next[c];
        end
    end

    // pipeline
    logic                    adv;
    logic [NS-1:0]           vld_reg, vld_next;
    lut3d_pkg::pl_t          pl_reg [NS];
    lut3d_pkg::pl_t          pl_next [NS];

    logic signed [VB:0]      t_reg [3], t_next [3];
    logic [VB-1:0]           tc_reg [3], tc_next [3];
    logic [VB-1:0]           rem_reg [DS][3], rem_next [DS][3];
    logic [lut3d_pkg::NORM_BITS-1:0] q_reg [DS][3], q_next [DS][3];
    logic [GB-1:0]           lo_reg [3], lo_next [3];
    logic                    one_reg [3], one_next [3];
    logic [AB-1:0]           base_reg, base_next;
    logic                    stp_r_reg, stp_r_next;
    logic [GB-1:0]           stp_g_reg, stp_g_next;
    logic [lut3d_pkg::SQ_BITS-1:0] stp_b_reg, stp_b_next;
    logic [AB-1:0]           addr_reg [lut3d_pkg::CORNERS];
    logic [AB-1:0]           addr_next [lut3d_pkg::CORNERS];
    logic [lut3d_pkg::ENTRY_BITS-1:0] rd_reg [lut3d_pkg::CORNERS];

    logic signed [VB:0]      bd_reg [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic signed [VB:0]      bd_next [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           ba_reg [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           ba_next [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic signed [lut3d_pkg::PROD_BITS-1:0] bm_reg [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic signed [lut3d_pkg::PROD_BITS-1:0] bm_next [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           bma_reg [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           bma_next [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           bv_reg [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];
    logic [VB-1:0]           bv_next [lut3d_pkg::LEVELS][lut3d_pkg::PAIRS][3];

    logic                    wr_en;

    assign m_valid = vld_reg[LAST] && (pl_reg[LAST].op == lut3d_pkg::OP_PIXEL);
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign wr_en   = adv && vld_reg[lut3d_pkg::ST_ADDR]
                  && (pl_reg[lut3d_pkg::ST_ADDR].op == lut3d_pkg::OP_WRITE)
                  && (pl_reg[lut3d_pkg::ST_ADDR].idx < AB'(lut3d_pkg::LUT_DEPTH));

    always_comb begin
        logic [VB:0]                        r2;
        logic [VB:0]                        r2d;
        logic                               ge;
        logic [lut3d_pkg::SCL_BITS-1:0]     scl;
        logic [AB-1:0]                      bterm, gterm;
        logic [VB-1:0]                      ain, zin;
        logic [FB-1:0]                      tl;
        logic signed [lut3d_pkg::PROD_BITS-1:0] rnd;

        vld_next = {vld_reg[NS-2:0], s_valid};

        pl_next[0].op   = lut3d_pkg::op_t'(s_operation);
        pl_next[0].idx  = s_entry_index;
        pl_next[0].px   = {s_blue, s_green, s_red};
        pl_next[0].frac = '0;
        for (int i = 1; i < NS; i++) begin
            pl_next[i] = pl_reg[i-1];
        end

        for (int c = 0; c < 3; c++) begin
            // offset from domain minimum
            t_next[c] = $signed({pl_next[0].px[c][VB-1], pl_next[0].px[c]})
                      - $signed({min_reg[c][VB-1], min_reg[c]});

            // clamp to [0, den]; empty domain gives zero
            if (!den_pos_reg[c] || t_reg[c][VB]) begin
                tc_next[c] = '0;
            end else if (t_reg[c] > $signed({1'b0, den_reg[c]})) begin
                tc_next[c] = den_reg[c];
            end else begin
                tc_next[c] = t_reg[c][VB-1:0];
            end

            // divider, integer bit first
            ge              = (tc_reg[c] == den_reg[c]);
            q_next[0][c]    = '0;
            q_next[0][c][FB] = ge;
            rem_next[0][c]  = ge ? '0 : tc_reg[c];
            for (int j = 1; j < DS; j++) begin
                r2  = {rem_reg[j-1][c], 1'b0};
                r2d = r2 - {1'b0, den_reg[c]};
                ge  = (r2 >= {1'b0, den_reg[c]});
                rem_next[j][c]       = ge ? r2d[VB-1:0] : r2[VB-1:0];
                q_next[j][c]         = q_reg[j-1][c];
                q_next[j][c][FB-j]   = ge;
            end

            // scale by N-1
            scl = lut3d_pkg::SCL_BITS'(q_reg[DS-1][c]) * lut3d_pkg::SCL_BITS'(nm1_reg);
            lo_next[c]  = scl[FB +: GB];
            one_next[c] = q_reg[DS-1][c][FB];
            pl_next[lut3d_pkg::ST_SCALE].frac[c] = scl[FB-1:0];
        end

        // base corner address and per-axis steps
        bterm      = AB'(lo_reg[2]) * AB'(nn_reg);
        gterm      = AB'(lo_reg[1]) * AB'(n_reg);
        base_next  = bterm + gterm + AB'(lo_reg[0]);
        stp_r_next = !one_reg[0];
        stp_g_next = one_reg[1] ? '0 : n_reg;
        stp_b_next = one_reg[2] ? '0 : nn_reg;

        // corner k: bit 0 red high, bit 1 green high, bit 2 blue high
        for (int k = 0; k < lut3d_pkg::CORNERS; k++) begin
            addr_next[k] = base_reg
                         + (k[0] ? AB'(stp_r_reg) : '0)
                         + (k[1] ? AB'(stp_g_reg) : '0)
                         + (k[2] ? AB'(stp_b_reg) : '0);
        end

        // blend levels: blue, then green, then red
        for (int l = 0; l < lut3d_pkg::LEVELS; l++) begin
            tl = pl_reg[lut3d_pkg::ST_BLEND + 3*l].frac[2-l];
            for (int p = 0; p < lut3d_pkg::PAIRS; p++) begin
                for (int c = 0; c < 3; c++) begin
                    ain = '0;
                    zin = '0;
                    if (l == 0) begin
                        ain = rd_reg[p][c*VB +: VB];
                        zin = rd_reg[p+4][c*VB +: VB];
                    end else if (l == 1 && p < 2) begin
                        ain = bv_reg[0][p][c];
                        zin = bv_reg[0][p+2][c];
                    end else if (l == 2 && p == 0) begin
                        ain = bv_reg[1][0][c];
                        zin = bv_reg[1][1][c];
                    end
                    bd_next[l][p][c]  = $signed({zin[VB-1], zin})
                                      - $signed({ain[VB-1], ain});
                    ba_next[l][p][c]  = ain;
                    bm_next[l][p][c]  = bd_reg[l][p][c] * $signed({1'b0, tl});
                    bma_next[l][p][c] = ba_reg[l][p][c];
                    rnd = (bm_reg[l][p][c] + lut3d_pkg::ROUND_HALF) >>> FB;
                    bv_next[l][p][c]  = rnd[VB-1:0] + bma_reg[l][p][c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                pl_reg[i] <= pl_next[i];
            end
            for (int c = 0; c < 3; c++) begin
                t_reg[c]   <= t_next[c];
                tc_reg[c]  <= tc_next[c];
                lo_reg[c]  <= lo_next[c];
                one_reg[c] <= one_next[c];
                for (int j = 0; j < DS; j++) begin
                    rem_reg[j][c] <= rem_next[j][c];
                    q_reg[j][c]   <= q_next[j][c];
                end
            end
            base_reg  <= base_next;
            stp_r_reg <= stp_r_next;
            stp_g_reg <= stp_g_next;
            stp_b_reg <= stp_b_next;
            for (int k = 0; k < lut3d_pkg::CORNERS; k++) begin
                addr_reg[k] <= addr_next[k];
            end
            for (int l = 0; l < lut3d_pkg::LEVELS; l++) begin
                for (int p = 0; p < lut3d_pkg::PAIRS; p++) begin
                    for (int c = 0; c < 3; c++) begin
                        bd_reg[l][p][c]  <= bd_next[l][p][c];
                        ba_reg[l][p][c]  <= ba_next[l][p][c];
                        bm_reg[l][p][c]  <= bm_next[l][p][c];
                        bma_reg[l][p][c] <= bma_next[l][p][c];
                        bv_reg[l][p][c]  <= bv_next[l][p][c];
                    end
                end
            end
        end
    end

    // table: eight replicated banks, one corner read from each
    logic [lut3d_pkg::ENTRY_BITS-1:0] bank_mem [lut3d_pkg::CORNERS][lut3d_pkg::LUT_DEPTH];

    always_ff @(posedge aclk) begin
        for (int k = 0; k < lut3d_pkg::CORNERS; k++) begin
            if (wr_en) begin
                bank_mem[k][pl_reg[lut3d_pkg::ST_ADDR].idx] <= pl_reg[lut3d_pkg::ST_ADDR].px;
            end
            if (adv) begin
                rd_reg[k] <= bank_mem[k][addr_reg[k]];
            end
        end
    end

    assign m_red_out   = bypass_reg ? pl_reg[LAST].px[0] : bv_reg[2][0][0];
    assign m_green_out = bypass_reg ? pl_reg[LAST].px[1] : bv_reg[2][0][1];
    assign m_blue_out  = bypass_reg ? pl_reg[LAST].px[2] : bv_reg[2][0][2];

    // checks
    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[lut3d_pkg::ST_IN])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    for (genvar c = 0; c < 3; c++) begin : g_chk
        a_norm_bound : assert property (@(posedge aclk) disable iff (!aresetn)
            vld_reg[lut3d_pkg::ST_SCALE-1] |-> (q_reg[DS-1][c] <= lut3d_pkg::ONE_NORM))
            else $error("normalised value above one");

        a_edge_frac : assert property (@(posedge aclk) disable iff (!aresetn)
            vld_reg[lut3d_pkg::ST_SCALE] && one_reg[c]
                |-> (pl_reg[lut3d_pkg::ST_SCALE].frac[c] == '0))
            else $error("non-zero fraction at upper grid edge");
    end

endmodule

/* bench/lut3d_map_checker.sv */
// Checker for the trilinear 3D colour look-up table: watches the input, result
// and register ports, predicts each mapped pixel and compares it field by field.
// Depends on lut3d_pkg (widths, op_t, reg_idx_t).
`timescale 1ns / 100ps

module lut3d_map_checker
    import lut3d_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_operation,
    input  logic [15:0]                  s_entry_index,
    input  logic signed [VALUE_BITS-1:0] s_red,
    input  logic signed [VALUE_BITS-1:0] s_green,
    input  logic signed [VALUE_BITS-1:0] s_blue,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [VALUE_BITS-1:0] m_red_out,
    input  logic signed [VALUE_BITS-1:0] m_green_out,
    input  logic signed [VALUE_BITS-1:0] m_blue_out,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [VALUE_BITS-1:0]        cfg_wdata,
    output int                           errors,
    output int                           outstanding,
    output int                           pixels_mapped,
    output int                           entries_loaded
);

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef struct packed {
        val_t r;
        val_t g;
        val_t b;
    } rgb_t;

    localparam longint UNIT = longint'(1) << FRAC_BITS;

    rgb_t       colour_table [LUT_DEPTH];
    rgb_t       mapped_q [$];
    logic [5:0] grid;
    val_t       dom_lo [3];
    val_t       dom_hi [3];

    function automatic longint norm_of(longint x, longint lo, longint hi);
        longint den;
        longint t;
        longint q;
        den = hi - lo;
        t = x - lo;
        if (den <= 0) begin
            return 0;
        end
        if (t < 0) t = 0;
        if (t > den) t = den;
        q = (t <<< FRAC_BITS) / den;
        return (q > UNIT) ? UNIT : q;
    endfunction

    function automatic longint blend_q(longint a, longint z, longint t);
        longint s;
        s = a * (UNIT - t) + z * t + (UNIT >>> 1);
        return s >>> FRAC_BITS;
    endfunction

    function automatic longint corner(int n, int r, int g, int b, int c);
        rgb_t e;
        e = colour_table[(b * n + g) * n + r];
        case (c)
            0: return longint'($signed(e.r));
            1: return longint'($signed(e.g));
            default: return longint'($signed(e.b));
        endcase
    endfunction

    function automatic rgb_t mapped_pixel(val_t r, val_t g, val_t b);
        longint px [3];
        longint nm;
        longint scaled;
        int     lo [3];
        int     hi [3];
        longint fr [3];
        longint c00, c01, c10, c11;
        val_t   res [3];
        int     n;
        n = (grid > MAX_GRID) ? MAX_GRID : int'(grid);
        if (n < 2) begin
            return '{r: r, g: g, b: b};
        end
        px[0] = longint'(r);
        px[1] = longint'(g);
        px[2] = longint'(b);
        for (int c = 0; c < 3; c++) begin
            nm = norm_of(px[c], longint'(dom_lo[c]), longint'(dom_hi[c]));
            scaled = nm * (n - 1);
            lo[c] = int'(scaled >>> FRAC_BITS);
            fr[c] = scaled & (UNIT - 1);
            hi[c] = (nm >= UNIT) ? lo[c] : lo[c] + 1;
        end
        for (int c = 0; c < 3; c++) begin
            c00 = blend_q(corner(n, lo[0], lo[1], lo[2], c),
                          corner(n, lo[0], lo[1], hi[2], c), fr[2]);
            c01 = blend_q(corner(n, lo[0], hi[1], lo[2], c),
                          corner(n, lo[0], hi[1], hi[2], c), fr[2]);
            c10 = blend_q(corner(n, hi[0], lo[1], lo[2], c),
                          corner(n, hi[0], lo[1], hi[2], c), fr[2]);
            c11 = blend_q(corner(n, hi[0], hi[1], lo[2], c),
                          corner(n, hi[0], hi[1], hi[2], c), fr[2]);
            res[c] = val_t'(blend_q(blend_q(c00, c01, fr[1]),
                                    blend_q(c10, c11, fr[1]), fr[0]));
        end
        return '{r: res[0], g: res[1], b: res[2]};
    endfunction

    task automatic report_mismatch(string what, val_t got, val_t want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        rgb_t want;
        if (!aresetn) begin
            grid = '0;
            for (int c = 0; c < 3; c++) begin
                dom_lo[c] = '0;
                dom_hi[c] = val_t'(UNIT);
            end
            mapped_q.delete();
            errors = 0;
            pixels_mapped <= 0;
            entries_loaded <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_GRID:      grid = cfg_wdata[5:0];
                    REG_MIN_RED:   dom_lo[0] = cfg_wdata;
                    REG_MIN_GREEN: dom_lo[1] = cfg_wdata;
                    REG_MIN_BLUE:  dom_lo[2] = cfg_wdata;
                    REG_MAX_RED:   dom_hi[0] = cfg_wdata;
                    REG_MAX_GREEN: dom_hi[1] = cfg_wdata;
                    REG_MAX_BLUE:  dom_hi[2] = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mapped_q.size() == 0) begin
                    report_mismatch("result transfer with none expected", m_red_out, '0);
                end else begin
                    want = mapped_q.pop_front();
                    if (m_red_out !== want.r)
                        report_mismatch("red_out", m_red_out, want.r);
                    if (m_green_out !== want.g)
                        report_mismatch("green_out", m_green_out, want.g);
                    if (m_blue_out !== want.b)
                        report_mismatch("blue_out", m_blue_out, want.b);
                end
            end
            if (s_valid && s_ready) begin
                if (op_t'(s_operation) == OP_WRITE) begin
                    if (s_entry_index < LUT_DEPTH)
                        colour_table[s_entry_index] = '{r: s_red, g: s_green, b: s_blue};
                    entries_loaded <= entries_loaded + 1;
                end else begin
                    mapped_q.push_back(mapped_pixel(s_red, s_green, s_blue));
                    pixels_mapped <= pixels_mapped + 1;
                end
            end
        end
        outstanding <= mapped_q.size();
    end

endmodule

/* bench/lut3d_trilinear_color_map_test.sv */
// Top of the colour look-up table bench: clock, reset, register set-up, table
// loads and pixel traffic. Depends on lut3d_pkg, lut3d_trilinear_color_map, lut3d_map_checker.
`timescale 1ns / 100ps

module lut3d_trilinear_color_map_test;
    import lut3d_pkg::*;

    typedef logic signed [VALUE_BITS-1:0] val_t;

    localparam int     VMIN      = -(1 << (VALUE_BITS - 1));
    localparam int     VMAX      = (1 << (VALUE_BITS - 1)) - 1;
    localparam longint MAX_CYCLE = 8_000_000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_operation = 1'b0;
    logic [15:0]             s_entry_index = '0;
    val_t                    s_red = '0;
    val_t                    s_green = '0;
    val_t                    s_blue = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    val_t                    m_red_out;
    val_t                    m_green_out;
    val_t                    m_blue_out;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [VALUE_BITS-1:0]   cfg_wdata = '0;

    int     errors;
    int     outstanding;
    int     pixels_mapped;
    int     entries_loaded;
    longint cycle_count = 0;
    bit     held = 1'b0;
    bit     tx_quiet = 1'b0;
    bit     rx_quiet = 1'b0;
    int     rx_stall = 0;
    int     grid_now = 0;
    int     lo_now [3] = '{0, 0, 0};
    int     hi_now [3] = '{65536, 65536, 65536};
    bit     loaded [LUT_DEPTH];

    lut3d_trilinear_color_map uut (.*);

    lut3d_map_checker chk (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
        if (!aresetn || rx_stall == 0) begin
            m_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 99) < 25) rx_stall = pick_gap(1'b0);
        end else begin
            m_ready <= 1'b0;
            rx_stall--;
        end
    end

    task automatic send(op_t op, int idx, val_t r, val_t g, val_t b);
        int gap;
        if ($urandom_range(0, 199) == 0) tx_quiet = !tx_quiet;
        gap = pick_gap(tx_quiet);
        if (held && gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            held = 1'b0;
            gap--;
        end
        repeat (gap) @(negedge aclk);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_operation <= op;
        s_entry_index <= idx[15:0];
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        do @(posedge aclk); while (!s_ready);
        held = 1'b1;
        if (op == OP_WRITE && idx >= 0 && idx < LUT_DEPTH) loaded[idx] = 1'b1;
    endtask

    // no new transfer until every expected result is out and the pipe is empty
    task automatic drain();
        if (held) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            held = 1'b0;
        end
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_reg(reg_idx_t idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[VALUE_BITS-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int grid, int lo_r, int lo_g, int lo_b,
                             int hi_r, int hi_g, int hi_b);
        drain();
        grid_now = grid;
        lo_now = '{lo_r, lo_g, lo_b};
        hi_now = '{hi_r, hi_g, hi_b};
        set_reg(REG_GRID, grid);
        set_reg(REG_MIN_RED, lo_r);
        set_reg(REG_MIN_GREEN, lo_g);
        set_reg(REG_MIN_BLUE, lo_b);
        set_reg(REG_MAX_RED, hi_r);
        set_reg(REG_MAX_GREEN, hi_g);
        set_reg(REG_MAX_BLUE, hi_b);
    endtask

    function automatic val_t any_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return val_t'(VMAX);
        if (r == 1) return val_t'(VMIN);
        return val_t'($urandom);
    endfunction

    // banded pixels stay in the cells next to the domain ends
    function automatic val_t pixel_value(int c, bit wide);
        int span;
        int band;
        int r;
        span = hi_now[c] - lo_now[c];
        band = span / 64;
        r = $urandom_range(0, 9);
        if (span <= 0 || (wide && r < 3)) return any_value();
        if (wide || grid_now <= 5)
            return val_t'(lo_now[c] + int'($urandom_range(0, span)));
        if (r == 0) return val_t'(VMIN);
        if (r == 1) return val_t'(VMAX);
        if (r < 6) return val_t'(lo_now[c] + int'($urandom_range(0, band)));
        return val_t'(hi_now[c] - int'($urandom_range(0, band)));
    endfunction

    function automatic longint norm_now(val_t x, int c);
        longint den;
        longint t;
        longint q;
        den = longint'(hi_now[c]) - longint'(lo_now[c]);
        t = longint'(x) - longint'(lo_now[c]);
        if (den <= 0) return 0;
        if (t < 0) t = 0;
        if (t > den) t = den;
        q = (t <<< FRAC_BITS) / den;
        return (q > (longint'(1) << FRAC_BITS)) ? (longint'(1) << FRAC_BITS) : q;
    endfunction

    // loads any of the pixel's eight corners not yet written, then sends it
    task automatic send_pixel(val_t r, val_t g, val_t b);
        val_t   px [3];
        int     n;
        int     lo [3];
        int     hi [3];
        int     idx;
        longint nm;
        longint scaled;
        px = '{r, g, b};
        n = (grid_now > MAX_GRID) ? MAX_GRID : grid_now;
        if (n >= 2) begin
            for (int c = 0; c < 3; c++) begin
                nm = norm_now(px[c], c);
                scaled = nm * (n - 1);
                lo[c] = int'(scaled >>> FRAC_BITS);
                hi[c] = (nm >= (longint'(1) << FRAC_BITS)) ? lo[c] : lo[c] + 1;
            end
            for (int k = 0; k < 8; k++) begin
                idx = ((k[2] ? hi[2] : lo[2]) * n + (k[1] ? hi[1] : lo[1])) * n
                    + (k[0] ? hi[0] : lo[0]);
                if (!loaded[idx])
                    send(OP_WRITE, idx, any_value(), any_value(), any_value());
            end
        end
        send(OP_PIXEL, $urandom_range(0, 65535), r, g, b);
    endtask

    task automatic random_domain(int grid);
        int lo [3];
        int hi [3];
        for (int c = 0; c < 3; c++) begin
            lo[c] = VMIN + int'($urandom_range(0, 900000));
            hi[c] = lo[c] + int'($urandom_range(1, VMAX - lo[c]));
        end
        configure(grid, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    task automatic random_traffic(int count);
        int n;
        bit wide;
        n = (grid_now > MAX_GRID) ? MAX_GRID : grid_now;
        if (n < 2) n = MAX_GRID;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 9) == 0)
                    send(OP_WRITE, $urandom_range(LUT_DEPTH, 65535),
                         any_value(), any_value(), any_value());
                else
                    send(OP_WRITE, $urandom_range(0, n * n * n - 1),
                         any_value(), any_value(), any_value());
            end else begin
                wide = ($urandom_range(0, 19) == 0);
                send_pixel(pixel_value(0, wide), pixel_value(1, wide),
                           pixel_value(2, wide));
            end
        end
    endtask

    initial begin
        int grids [8] = '{2, 3, 33, 17, 63, 5, 1, 9};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bypass with reset registers, then grid of one
        send(OP_PIXEL, 0, val_t'(VMAX), val_t'(VMIN), '0);
        send(OP_PIXEL, 16'hFFFF, val_t'(VMIN), val_t'(VMAX), val_t'(-1));
        send(OP_PIXEL, 0, val_t'(65536), val_t'(1), val_t'(32768));
        configure(1, 0, 0, 0, 65536, 65536, 65536);
        send(OP_PIXEL, 0, val_t'(12345), val_t'(-7), val_t'(VMAX));

        // domain edges, below and above the domain, out-of-range writes
        configure(MAX_GRID, 0, 0, 0, 65536, 65536, 65536);
        send_pixel('0, '0, '0);
        send_pixel(val_t'(65536), val_t'(65536), val_t'(65536));
        send_pixel(val_t'(VMIN), val_t'(VMAX), val_t'(32768));
        send_pixel(val_t'(65535), val_t'(1), val_t'(-1));
        send(OP_WRITE, LUT_DEPTH, val_t'(VMAX), val_t'(VMAX), val_t'(VMAX));
        send(OP_WRITE, 65535, val_t'(VMIN), val_t'(VMIN), val_t'(VMIN));
        send(OP_WRITE, LUT_DEPTH - 1, val_t'(VMAX), val_t'(VMIN), val_t'(VMAX));
        send_pixel(val_t'(65536), val_t'(65536), val_t'(65536));
        send(OP_WRITE, 0, val_t'(VMIN), val_t'(VMAX), '0);
        send_pixel('0, '0, '0);

        // widest domain, then empty domains, then oversized grid
        configure(MAX_GRID, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX);
        send_pixel(val_t'(VMIN), val_t'(VMAX), '0);
        send_pixel(val_t'(VMAX), val_t'(VMIN), val_t'(-1));
        configure(MAX_GRID, 100, VMAX, 0, 100, VMIN, -5);
        send_pixel(val_t'(VMAX), val_t'(VMIN), '0);
        configure(63, 0, 0, 0, 65536, 65536, 65536);
        send_pixel(val_t'(40000), val_t'(20000), val_t'(65536));
        send_pixel(val_t'(65536), '0, val_t'(3));

        foreach (grids[p]) begin
            if (p == 0)
                configure(grids[p], 0, 0, 0, 65536, 65536, 65536);
            else if (p == 3)
                configure(grids[p], VMIN, VMIN, VMIN, VMAX, VMAX, VMAX);
            else
                random_domain(grids[p]);
            random_traffic(60);
        end
        random_domain(0);
        random_traffic(40);

        drain();
        $display("%0d table writes and %0d pixels sent over grids 0 to 63, bypass and",
                 entries_loaded, pixels_mapped);
        $display("empty, full and random domains, with gaps and stalls on both sides");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* lut3d_trilinear_color_map.f */
design/lut3d_pkg.sv
design/lut3d_trilinear_color_map.sv
bench/lut3d_map_checker.sv
bench/lut3d_trilinear_color_map_test.sv
